[rtl/rswh_pkg.sv]
`default_nettype none

package rswh_pkg;

	localparam int CNT_W  = 23;
	localparam int SUM_W  = 56;
	localparam int WGT_W  = 32;
	localparam int GRAY_W = 8;
	localparam int MASK_W = 8;
	localparam int REQ_W  = 2;

	localparam int DEF_GRAY_LEVELS = 256;

	// Request codes; the fourth code is a no-op.
	localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic [GRAY_W-1:0]        gray_level;
		logic [MASK_W-1:0]        roi_mask;
		logic signed [WGT_W-1:0]  attack_value;
	} hist_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]         inside_count;
		logic [CNT_W-1:0]         outside_count;
		logic signed [SUM_W-1:0]  bin_weight_sum;
		logic [CNT_W-1:0]         total_inside;
		logic [CNT_W-1:0]         total_outside;
		logic signed [SUM_W-1:0]  total_weight_sum;
	} hist_rsp_t;

	// One histogram bin, or the set of grand totals.
	typedef struct packed {
		logic [CNT_W-1:0]         inside_cnt;
		logic [CNT_W-1:0]         outside_cnt;
		logic signed [SUM_W-1:0]  wsum;
	} bin_entry_t;

	typedef bin_entry_t totals_t;

endpackage

`default_nettype wire

[rtl/rswh_ram.sv]
`default_nettype none

module rswh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/rswh_update.sv]
`default_nettype none

module rswh_update
	import rswh_pkg::*;
(
	input  wire logic                    in_roi,
	input  wire logic signed [WGT_W-1:0] weight,
	input  wire bin_entry_t              bin_in,
	input  wire totals_t                 tot_in,
	output bin_entry_t                   bin_out,
	output totals_t                      tot_out
);

	// Hold at all ones once the count gets there.
	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		cnt_inc = (&c) ? c : c + 1'b1;
	endfunction

	// Exact add with clamp to the signed range of the sum.
	function automatic logic signed [SUM_W-1:0] sum_add(
		input logic signed [SUM_W-1:0] a,
		input logic signed [WGT_W-1:0] w
	);
		logic [SUM_W:0] s;
		s = {a[SUM_W-1], a} + {{(SUM_W + 1 - WGT_W){w[WGT_W-1]}}, w};
		if (s[SUM_W] != s[SUM_W-1]) begin
			sum_add = s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_add = s[SUM_W-1:0];
		end
	endfunction

	always_comb begin
		bin_out = bin_in;
		tot_out = tot_in;
		if (in_roi) begin
			bin_out.inside_cnt = cnt_inc(bin_in.inside_cnt);
			bin_out.wsum       = sum_add(bin_in.wsum, weight);
			tot_out.inside_cnt = cnt_inc(tot_in.inside_cnt);
			tot_out.wsum       = sum_add(tot_in.wsum, weight);
		end else begin
			bin_out.outside_cnt = cnt_inc(bin_in.outside_cnt);
			tot_out.outside_cnt = cnt_inc(tot_in.outside_cnt);
		end
	end

endmodule

`default_nettype wire

[rtl/roi_split_weighted_histogram_unit.sv]
`default_nettype none
// A read transaction passes the input register, then the result register, and shows its result
//   with done high for one cycle;
//   accumulate and clear give no result.
// Throughput: one transaction per cycle; busy stays low, so start is taken every cycle.
// Reset (arst_n low, asynchronous) clears every bin valid bit and the three totals.
// The receiver cannot stall; done flags each result for exactly one cycle, and rsp holds it until the next read.

module roi_split_weighted_histogram_unit
	import rswh_pkg::*;
#(
	parameter int GRAY_LEVELS = DEF_GRAY_LEVELS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire hist_req_t req,
	output logic           done,
	output hist_rsp_t      rsp
);

	localparam int              AW     = $clog2(GRAY_LEVELS);
	localparam int              BIN_W  = $bits(bin_entry_t);
	localparam logic [GRAY_W:0] LEVELS = (GRAY_W + 1)'(GRAY_LEVELS);

	logic       accept;
	logic       vld_s1;
	hist_req_t  req_s1;

	logic [GRAY_LEVELS-1:0] bin_valid_q;
	totals_t                tot_q;

	// Last bin written, to cover the RAM's read-before-write on back-to-back hits.
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	bin_entry_t       fwd_data_q;

	logic [BIN_W-1:0] ram_rdata;
	logic [AW-1:0]    addr_s1;
	logic             in_range_s1;
	logic             fwd_hit;
	bin_entry_t       base_bin;
	bin_entry_t       new_bin;
	totals_t          new_tot;
	logic             do_acc;
	logic             do_rd;
	logic             do_clr;

	logic      done_q;
	hist_rsp_t rsp_q;

	// Never back-pressure: no stage ever holds a transaction back.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Input stage register: capture the transaction while the RAM reads its bin.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign addr_s1     = req_s1.gray_level[AW-1:0];
	assign in_range_s1 = {1'b0, req_s1.gray_level} < LEVELS;
	assign do_acc      = vld_s1 && (req_s1.req_type == REQ_ACCUM) && in_range_s1;
	assign do_rd       = vld_s1 && (req_s1.req_type == REQ_READ);
	assign do_clr      = vld_s1 && (req_s1.req_type == REQ_CLEAR);

	rswh_ram #(
		.WIDTH (BIN_W),
		.DEPTH (GRAY_LEVELS)
	) u_bin_ram (
		.clk   (clk),
		.we    (do_acc),
		.waddr (addr_s1),
		.wdata (new_bin),
		.re    (accept),
		.raddr (req.gray_level[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Pick the bin's current contents: an invalid or out-of-range bin reads as zero,
	// otherwise take the last bin written if it is the same one, else the RAM.
	assign fwd_hit = fwd_vld_q && (fwd_addr_q == addr_s1);

	always_comb begin
		if (!in_range_s1 || !bin_valid_q[addr_s1]) begin
			base_bin = '0;
		end else if (fwd_hit) begin
			base_bin = fwd_data_q;
		end else begin
			base_bin = bin_entry_t'(ram_rdata);
		end
	end

	rswh_update u_update (
		.in_roi  (req_s1.roi_mask != '0),
		.weight  (req_s1.attack_value),
		.bin_in  (base_bin),
		.tot_in  (tot_q),
		.bin_out (new_bin),
		.tot_out (new_tot)
	);

	// Control state: valid bits, totals, the forwarding tag and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			tot_q       <= '0;
			fwd_vld_q   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= do_rd;
			if (do_clr) begin
				bin_valid_q <= '0;
				tot_q       <= '0;
				fwd_vld_q   <= 1'b0;
			end else if (do_acc) begin
				bin_valid_q[addr_s1] <= 1'b1;
				tot_q                <= new_tot;
				fwd_vld_q            <= 1'b1;
			end
		end
	end

	// Payload: forwarding data and the result register.
	always_ff @(posedge clk) begin
		if (do_acc) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_bin;
		end
		if (do_rd) begin
			rsp_q.inside_count     <= base_bin.inside_cnt;
			rsp_q.outside_count    <= base_bin.outside_cnt;
			rsp_q.bin_weight_sum   <= base_bin.wsum;
			rsp_q.total_inside     <= tot_q.inside_cnt;
			rsp_q.total_outside    <= tot_q.outside_cnt;
			rsp_q.total_weight_sum <= tot_q.wsum;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_done_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(do_rd))
		else $error("result strobe without a read transaction");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		do_clr |=> (tot_q == '0) && (bin_valid_q == '0) && !fwd_vld_q)
		else $error("clear left state behind");

	a_acc_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_acc |=> bin_valid_q[$past(addr_s1)] && fwd_vld_q)
		else $error("accumulate did not mark its bin valid");

	a_totals_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !do_clr |=> (tot_q.inside_cnt >= $past(tot_q.inside_cnt))
			&& (tot_q.outside_cnt >= $past(tot_q.outside_cnt)))
		else $error("total count decreased without a clear");
`endif

endmodule

`default_nettype wire
